>>> rtl/assert_macros.svh
// Assertion macros for the checker file of the project (cldr_chk).
// Plain text only: cldr_chk includes this header, which depends on no package.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is asserted (reset active low)
`define ASSERT_CLKD(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked check that also holds during reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/cldr_pkg.sv
// Shared types and constants for the character LCD refresh block.
// No dependencies; cldr_dp, cldr_ctrl and the top level refer to it by scoped names.
package cldr_pkg;

    localparam int LINE_CHARS = 16;
    localparam int LINES      = 2;
    localparam int CELLS      = LINE_CHARS * LINES;
    localparam int COL_W      = $clog2(LINE_CHARS);
    localparam int ROW_W      = 1;
    localparam int IDX_W      = $clog2(CELLS);

    // Input item kinds
    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_PLACE = 2'd1;
    localparam logic [1:0] KIND_MARK  = 2'd2;
    localparam logic [1:0] KIND_TICK  = 2'd3;

    // Configuration register indexes
    localparam logic REG_REFRESH_INTERVAL = 1'b0;
    localparam logic REG_BLANK_TIMEOUT    = 1'b1;

    localparam logic [15:0] REFRESH_RST = 16'd100;
    localparam logic [21:0] BLANK_RST   = 22'd60000;

    // Panel commands
    localparam logic [7:0] CMD_LOCATE   = 8'h80;
    localparam logic [7:0] CMD_DISP_ON  = 8'h0C;
    localparam logic [7:0] CMD_DISP_OFF = 8'h08;
    localparam logic [7:0] LOC_COL_MASK = 8'h3F;
    localparam int         LOC_ROW_SHIFT = 6;

    // Byte source for an emitted transaction
    localparam logic [1:0] EMIT_LOC  = 2'd0;
    localparam logic [1:0] EMIT_CHAR = 2'd1;
    localparam logic [1:0] EMIT_ON   = 2'd2;
    localparam logic [1:0] EMIT_OFF  = 2'd3;

    typedef struct packed {
        logic       write_char;
        logic       place;
        logic       mark_all;
        logic       tick;
        logic       scan_start;
        logic       advance;
        logic       clear_cell;
        logic       emit;
        logic [1:0] emit_sel;
        logic       final_upd;
        logic       flush;
    } cmd_t;

    typedef struct packed {
        logic due;
        logic cell_dirty;
        logic run_start;
        logic last_cell;
        logic room;
        logic disp_on_need;
        logic disp_off_need;
        logic emit_ok;
        logic flush_ok;
    } sts_t;

endpackage

>>> rtl/cldr_dp.sv
// Datapath: shadow screen, dirty marks, cursor, millisecond clock, deadline
// logic and the output staging. Depends on cldr_pkg.
module cldr_dp (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  cldr_pkg::cmd_t            cmd,
    output cldr_pkg::sts_t            sts,
    input  logic [7:0]                in_char,
    input  logic [cldr_pkg::COL_W-1:0] in_col,
    input  logic                      in_row,
    input  logic                      in_room,
    input  logic                      cfg_we,
    input  logic                      cfg_index,
    input  logic [21:0]               cfg_data,
    input  logic                      m_tready,
    output logic                      out_vld,
    output logic                      out_isd,
    output logic [7:0]                out_byte,
    output logic                      out_last
);

    localparam int COL_W = cldr_pkg::COL_W;
    localparam int ROW_W = cldr_pkg::ROW_W;
    localparam int IDX_W = cldr_pkg::IDX_W;
    localparam int CELLS = cldr_pkg::CELLS;

    logic [15:0]       refresh_iv_reg;
    logic [21:0]       blank_to_reg;
    logic [31:0]       now_reg;
    logic [31:0]       last_ref_reg;
    logic [31:0]       deadline_reg;
    logic [COL_W-1:0]  cur_col_reg;
    logic [ROW_W-1:0]  cur_row_reg;
    logic [7:0]        char_reg [CELLS];
    logic [CELLS-1:0]  dirty_reg;
    logic [IDX_W-1:0]  scan_idx_reg;
    logic [COL_W-1:0]  scan_col_reg;
    logic [ROW_W-1:0]  scan_row_reg;
    logic              prev_dirty_reg;
    logic              any_reg;
    logic              room_reg;
    logic              pend_vld_reg;
    logic              pend_isd_reg;
    logic [7:0]        pend_byte_reg;
    logic              out_vld_reg;
    logic              out_isd_reg;
    logic [7:0]        out_byte_reg;
    logic              out_last_reg;

    logic [IDX_W-1:0]  cur_idx;
    logic              cur_last_col;
    logic              scan_last_col;
    logic [31:0]       ref_diff;
    logic [31:0]       dl_sum;
    logic [31:0]       dl_diff;
    logic [7:0]        loc_byte;
    logic [7:0]        emit_byte;
    logic              out_free;

    assign cur_idx       = IDX_W'(cur_row_reg) * IDX_W'(cldr_pkg::LINE_CHARS)
                         + IDX_W'(cur_col_reg);
    assign cur_last_col  = (cur_col_reg == COL_W'(cldr_pkg::LINE_CHARS - 1));
    assign scan_last_col = (scan_col_reg == COL_W'(cldr_pkg::LINE_CHARS - 1));
    assign ref_diff      = now_reg - last_ref_reg;
    assign dl_sum        = now_reg + 32'(blank_to_reg);
    assign dl_diff       = now_reg - deadline_reg;
    assign out_free      = !out_vld_reg || m_tready;

    assign loc_byte = cldr_pkg::CMD_LOCATE
                    | (8'(scan_row_reg) << cldr_pkg::LOC_ROW_SHIFT)
                    | (8'(scan_col_reg) & cldr_pkg::LOC_COL_MASK);

    always_comb begin
        case (cmd.emit_sel)
            cldr_pkg::EMIT_LOC:  emit_byte = loc_byte;
            cldr_pkg::EMIT_CHAR: emit_byte = char_reg[scan_idx_reg];
            cldr_pkg::EMIT_ON:   emit_byte = cldr_pkg::CMD_DISP_ON;
            cldr_pkg::EMIT_OFF:  emit_byte = cldr_pkg::CMD_DISP_OFF;
            default:             emit_byte = 8'h00;
        endcase
    end

    always_comb begin
        sts.due           = (ref_diff >= 32'(refresh_iv_reg));
        sts.cell_dirty    = dirty_reg[scan_idx_reg];
        sts.run_start     = dirty_reg[scan_idx_reg] && !prev_dirty_reg;
        sts.last_cell     = (scan_idx_reg == IDX_W'(CELLS - 1));
        sts.room          = room_reg;
        sts.disp_on_need  = any_reg && (deadline_reg == 32'd0);
        sts.disp_off_need = !any_reg && (deadline_reg != 32'd0)
                          && (dl_diff != 32'd0) && !dl_diff[31];
        sts.emit_ok       = !pend_vld_reg || out_free;
        sts.flush_ok      = !pend_vld_reg || out_free;
    end

    // Configuration and timekeeping
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            refresh_iv_reg <= cldr_pkg::REFRESH_RST;
            blank_to_reg   <= cldr_pkg::BLANK_RST;
            now_reg        <= '0;
            last_ref_reg   <= '0;
            deadline_reg   <= 32'(cldr_pkg::BLANK_RST);
            room_reg       <= 1'b0;
            any_reg        <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    cldr_pkg::REG_REFRESH_INTERVAL: refresh_iv_reg <= cfg_data[15:0];
                    cldr_pkg::REG_BLANK_TIMEOUT:    blank_to_reg   <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.tick) begin
                now_reg  <= now_reg + 32'd1;
                room_reg <= in_room;
            end
            if (cmd.scan_start) begin
                last_ref_reg <= last_ref_reg + 32'(refresh_iv_reg);
                any_reg      <= |dirty_reg;
            end
            if (cmd.final_upd) begin
                if (any_reg) begin
                    deadline_reg <= (dl_sum == 32'd0) ? 32'd1 : dl_sum;
                end else if (sts.disp_off_need) begin
                    deadline_reg <= 32'd0;
                end
            end
        end
    end

    // Shadow screen, cursor and scan position
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < CELLS; i++) begin
                char_reg[i] <= 8'h00;
            end
            dirty_reg      <= '0;
            cur_col_reg    <= '0;
            cur_row_reg    <= '0;
            scan_idx_reg   <= '0;
            scan_col_reg   <= '0;
            scan_row_reg   <= '0;
            prev_dirty_reg <= 1'b0;
        end else begin
            if (cmd.write_char) begin
                char_reg[cur_idx]  <= in_char;
                dirty_reg[cur_idx] <= 1'b1;
                if (cur_last_col) begin
                    cur_col_reg <= '0;
                    cur_row_reg <= (cur_row_reg == ROW_W'(cldr_pkg::LINES - 1))
                                 ? '0 : cur_row_reg + ROW_W'(1);
                end else begin
                    cur_col_reg <= cur_col_reg + COL_W'(1);
                end
            end
            if (cmd.place) begin
                cur_col_reg <= in_col;
                cur_row_reg <= (32'(in_row) < cldr_pkg::LINES) ? ROW_W'(in_row) : '0;
            end
            if (cmd.mark_all) begin
                dirty_reg <= '1;
            end
            if (cmd.clear_cell) begin
                dirty_reg[scan_idx_reg] <= 1'b0;
            end
            if (cmd.scan_start) begin
                scan_idx_reg   <= '0;
                scan_col_reg   <= '0;
                scan_row_reg   <= '0;
                prev_dirty_reg <= 1'b0;
            end else if (cmd.advance) begin
                scan_idx_reg   <= scan_idx_reg + IDX_W'(1);
                prev_dirty_reg <= scan_last_col ? 1'b0 : dirty_reg[scan_idx_reg];
                if (scan_last_col) begin
                    scan_col_reg <= '0;
                    scan_row_reg <= scan_row_reg + ROW_W'(1);
                end else begin
                    scan_col_reg <= scan_col_reg + COL_W'(1);
                end
            end
        end
    end

    // One byte held back so that the final byte of a tick can carry last
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end else begin
            if (cmd.emit && pend_vld_reg) begin
                out_vld_reg  <= 1'b1;
                out_isd_reg  <= pend_isd_reg;
                out_byte_reg <= pend_byte_reg;
                out_last_reg <= 1'b0;
            end else if (cmd.flush && pend_vld_reg) begin
                out_vld_reg  <= 1'b1;
                out_isd_reg  <= pend_isd_reg;
                out_byte_reg <= pend_byte_reg;
                out_last_reg <= 1'b1;
            end else if (m_tready) begin
                out_vld_reg <= 1'b0;
            end
            if (cmd.emit) begin
                pend_vld_reg  <= 1'b1;
                pend_isd_reg  <= (cmd.emit_sel == cldr_pkg::EMIT_CHAR);
                pend_byte_reg <= emit_byte;
            end else if (cmd.flush) begin
                pend_vld_reg <= 1'b0;
            end
        end
    end

    assign out_vld  = out_vld_reg;
    assign out_isd  = out_isd_reg;
    assign out_byte = out_byte_reg;
    assign out_last = out_last_reg;

endmodule

>>> rtl/cldr_ctrl.sv
// Controller: sequences item handling, the refresh check, the cell scan,
// the display on/off step and the final flush. Depends on cldr_pkg.
module cldr_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [1:0]     kind,
    input  cldr_pkg::sts_t sts,
    output cldr_pkg::cmd_t cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CHECK = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_FINAL = 3'd3;
    localparam logic [2:0] ST_FLUSH = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       loc_sent_reg;
    logic       loc_sent_next;
    logic       disp_need;

    assign s_tready  = (state_reg == ST_IDLE);
    assign disp_need = sts.disp_on_need || sts.disp_off_need;

    always_comb begin
        cmd           = '0;
        state_next    = state_reg;
        loc_sent_next = loc_sent_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    case (kind)
                        cldr_pkg::KIND_WRITE: cmd.write_char = 1'b1;
                        cldr_pkg::KIND_PLACE: cmd.place      = 1'b1;
                        cldr_pkg::KIND_MARK:  cmd.mark_all   = 1'b1;
                        cldr_pkg::KIND_TICK: begin
                            cmd.tick   = 1'b1;
                            state_next = ST_CHECK;
                        end
                        default: ;
                    endcase
                end
            end
            ST_CHECK: begin
                if (sts.due) begin
                    cmd.scan_start = 1'b1;
                    loc_sent_next  = 1'b0;
                    state_next     = ST_SCAN;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN: begin
                if (sts.cell_dirty && sts.room) begin
                    if (sts.run_start && !loc_sent_reg) begin
                        // open the run with a locate command
                        if (sts.emit_ok) begin
                            cmd.emit      = 1'b1;
                            cmd.emit_sel  = cldr_pkg::EMIT_LOC;
                            loc_sent_next = 1'b1;
                        end
                    end else if (sts.emit_ok) begin
                        cmd.emit       = 1'b1;
                        cmd.emit_sel   = cldr_pkg::EMIT_CHAR;
                        cmd.clear_cell = 1'b1;
                        cmd.advance    = 1'b1;
                        loc_sent_next  = 1'b0;
                        if (sts.last_cell) begin
                            state_next = ST_FINAL;
                        end
                    end
                end else begin
                    cmd.advance = 1'b1;
                    if (sts.last_cell) begin
                        state_next = ST_FINAL;
                    end
                end
            end
            ST_FINAL: begin
                if (!disp_need || sts.emit_ok) begin
                    cmd.emit      = disp_need;
                    cmd.emit_sel  = sts.disp_on_need ? cldr_pkg::EMIT_ON : cldr_pkg::EMIT_OFF;
                    cmd.final_upd = 1'b1;
                    state_next    = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (sts.flush_ok) begin
                    cmd.flush  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            loc_sent_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            loc_sent_reg <= loc_sent_next;
        end
    end

endmodule

>>> rtl/char_lcd_dirty_refresh.sv
// Top level of the character LCD shadow-screen refresher.
// Joins cldr_ctrl and cldr_dp; depends on cldr_pkg.
//
//  channel   direction  handshake             payload
//  s_*       in         s_tvalid / s_tready   s_tdata, s_tuser (kind)
//  m_*       out        m_tvalid / m_tready   m_tdata, m_tuser, m_tlast
//  cfg_*     in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// A tick checks whether a refresh is due; a refresh walks the 32 cells one per cycle
// unless the output stalls (m_tready low), is held for each run's locate command (at
// most 16 runs), then does the display step and flush. Output bytes pass through a
// one-deep hold stage and an output register. Reset (aresetn low, synchronous)
// clears the screen, dirty marks, cursor and clocks at once and loads the
// configuration defaults; the output payload registers are not reset.
module char_lcd_dirty_refresh (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // char_code[7:0], col[11:8], row[12], room[13]
    input  logic [1:0]  s_tuser,   // kind[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // out_byte[7:0]
    output logic        m_tuser,   // is_data[0]
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [21:0] cfg_data
);

    cldr_pkg::cmd_t cmd;
    cldr_pkg::sts_t sts;
    logic           s_accept;

    assign cfg_ready = 1'b1;
    assign s_accept  = s_tvalid && s_tready;

    cldr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .kind     (s_tuser),
        .sts      (sts),
        .cmd      (cmd)
    );

    cldr_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .in_char   (s_tdata[7:0]),
        .in_col    (s_tdata[11:8]),
        .in_row    (s_tdata[12]),
        .in_room   (s_tdata[13] && s_accept),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tready  (m_tready),
        .out_vld   (m_tvalid),
        .out_isd   (m_tuser),
        .out_byte  (m_tdata),
        .out_last  (m_tlast)
    );

endmodule

>>> rtl/cldr_chk.sv
// Port-level checker for char_lcd_dirty_refresh, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module cldr_chk (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);

    `ASSERT_CLKD(a_hold_valid, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid, "stalled transaction dropped")
    `ASSERT_CLKD(a_hold_data, aclk, aresetn, m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled payload changed")
    `ASSERT_CLKD(a_disp_last, aclk, aresetn, m_tvalid && !m_tuser && (m_tdata == 8'h0C || m_tdata == 8'h08) |-> m_tlast, "display command not last of tick")
    `ASSERT_CLKD(a_loc_not_last, aclk, aresetn, m_tvalid && !m_tuser && m_tdata[7] |-> !m_tlast, "locate command closes a tick")
    `ASSERT_ALWAYS(a_reset_idle, aclk, !aresetn |=> !m_tvalid, "output valid after reset")

endmodule

bind char_lcd_dirty_refresh cldr_chk u_cldr_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
